// ===== hw/rtl/csch_pkg.sv =====
// ----------------------------------------------------------------------------
// csch_pkg
// Shared types, constants and helpers for the counter priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package csch_pkg;

  // default sizing
  localparam int SLOTS_DEF     = 16;
  localparam int PRIO_BITS_DEF = 7;

  // fixed field widths
  localparam int CMD_W      = 3;
  localparam int IDX_IN_W   = 4;
  localparam int STATE_W    = 2;
  localparam int PRIO_IN_W  = 7;
  localparam int PRIO_MAX_W = 15;
  localparam int CTR_W      = 8;
  localparam int DEPTH_W    = 4;
  localparam int SLOT_OUT_W = 4;
  localparam int TICK_W     = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd15;
  localparam logic [CTR_W-1:0]   CTR_MAX   = 8'hFF;

  // run state codes
  localparam logic [STATE_W-1:0] RS_RUN  = 2'd0;
  localparam logic [STATE_W-1:0] RS_EXIT = 2'd1;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_YIELD = 3'd1,
    CMD_EXIT  = 3'd2,
    CMD_PDIS  = 3'd3,
    CMD_PEN   = 3'd4,
    CMD_WRITE = 3'd5
  } cmd_t;

  // sequencer to compare unit
  typedef struct packed {
    logic clear;
    logic step;
  } pick_ctl_t;

  // recharge: counter/2 + priority, saturating
  function automatic logic [CTR_W-1:0] recharge(input logic [CTR_W-1:0] ctr,
                                                input logic [PRIO_MAX_W-1:0] prio);
    logic [PRIO_MAX_W:0] sum;
    sum = (PRIO_MAX_W+1)'(ctr >> 1) + (PRIO_MAX_W+1)'(prio);
    return (sum > (PRIO_MAX_W+1)'(CTR_MAX)) ? CTR_MAX : sum[CTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csch_slot_mem.sv =====
// ----------------------------------------------------------------------------
// csch_slot_mem
// Slot table: one write port, one registered read port. The preemption depth
// sits in its own store with its own write enable, so a slot write can leave
// it alone. Entries never written read back as their reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module csch_slot_mem
  import csch_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic                     wr_depth_en,
  input  logic [$clog2(SLOTS)-1:0] wr_addr,
  input  logic                     wr_valid,
  input  logic [STATE_W-1:0]       wr_state,
  input  logic [CTR_W-1:0]         wr_ctr,
  input  logic [PRIORITY_BITS-1:0] wr_prio,
  input  logic [DEPTH_W-1:0]       wr_depth,
  input  logic                     rd_en,
  input  logic [$clog2(SLOTS)-1:0] rd_addr,
  output logic                     rd_vld,
  output logic [$clog2(SLOTS)-1:0] rd_idx,
  output logic                     rd_valid,
  output logic [STATE_W-1:0]       rd_state,
  output logic [CTR_W-1:0]         rd_ctr,
  output logic [PRIORITY_BITS-1:0] rd_prio,
  output logic [DEPTH_W-1:0]       rd_depth
);

  localparam int W = 1 + STATE_W + CTR_W + PRIORITY_BITS;

  logic [W-1:0]       mem [SLOTS];
  logic [DEPTH_W-1:0] depth_mem [SLOTS];
  logic [SLOTS-1:0]   written;
  logic [SLOTS-1:0]   depth_written;
  logic [W-1:0]       rd_word;
  logic [DEPTH_W-1:0] rd_depth_word;
  logic               rd_written;
  logic               rd_depth_written;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_state, wr_ctr, wr_prio};
    end
    if (wr_depth_en) begin
      depth_mem[wr_addr] <= wr_depth;
    end
    if (rd_en) begin
      rd_word          <= mem[rd_addr];
      rd_depth_word    <= depth_mem[rd_addr];
      rd_idx           <= rd_addr;
      rd_written       <= written[rd_addr];
      rd_depth_written <= depth_written[rd_addr];
    end
  end

  // written marks and read strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      written       <= '0;
      depth_written <= '0;
      rd_vld        <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (wr_depth_en) begin
        depth_written[wr_addr] <= 1'b1;
      end
      rd_vld <= rd_en;
    end
  end

  // reset view: only slot 0 valid, priority 1, rest zero
  always_comb begin
    if (rd_written) begin
      {rd_valid, rd_state, rd_ctr, rd_prio} = rd_word;
    end else begin
      rd_valid = (rd_idx == '0);
      rd_state = RS_RUN;
      rd_ctr   = '0;
      rd_prio  = PRIORITY_BITS'(1);
    end
    rd_depth = rd_depth_written ? rd_depth_word : '0;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csch_pick_unit.sv =====
// ----------------------------------------------------------------------------
// csch_pick_unit
// Shared compare unit: takes one slot per step and keeps the runnable slot
// with the largest counter, lowest index on ties.
// ----------------------------------------------------------------------------
`default_nettype none

module csch_pick_unit
  import csch_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pick_ctl_t                ctl,
  input  logic [$clog2(SLOTS)-1:0] idx,
  input  logic                     valid,
  input  logic [STATE_W-1:0]       state,
  input  logic [CTR_W-1:0]         ctr,
  output logic                     found,
  output logic [CTR_W-1:0]         best,
  output logic [$clog2(SLOTS)-1:0] sel,
  output logic [CTR_W-1:0]         ctr0
);

  logic take;

  // strictly larger wins, so the first of equal counters stays
  assign take = valid && (state == RS_RUN) && (!found || (ctr > best));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.step && take) begin
      found <= 1'b1;
    end
  end

  // best, winner and slot 0 counter (fallback result)
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (take) begin
        best <= ctr;
        sel  <= idx;
      end
      if (idx == '0) begin
        ctr0 <= ctr;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/csch_ctrl.sv =====
// ----------------------------------------------------------------------------
// csch_ctrl
// Sequencer: applies a command to the running slot, then, if it schedules,
// walks the slot table through the compare unit, with an optional recharge
// sweep and second walk. Holds the running slot, tick total, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module csch_ctrl
  import csch_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // command beat
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [IDX_IN_W-1:0]      slot_index,
  input  logic                     slot_valid,
  input  logic [STATE_W-1:0]       slot_state,
  input  logic [PRIO_IN_W-1:0]     slot_priority,
  input  logic [CTR_W-1:0]         slot_counter,
  // result beat
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [SLOT_OUT_W-1:0]    current_slot,
  output logic [SLOT_OUT_W-1:0]    previous_slot,
  output logic                     switched,
  output logic                     recharged,
  output logic [TICK_W-1:0]        tick_count,
  output logic [CTR_W-1:0]         current_counter,
  // slot table
  output logic                     wr_en,
  output logic                     wr_depth_en,
  output logic [$clog2(SLOTS)-1:0] wr_addr,
  output logic                     wr_valid,
  output logic [STATE_W-1:0]       wr_state,
  output logic [CTR_W-1:0]         wr_ctr,
  output logic [PRIORITY_BITS-1:0] wr_prio,
  output logic [DEPTH_W-1:0]       wr_depth,
  output logic                     rd_en,
  output logic [$clog2(SLOTS)-1:0] rd_addr,
  input  logic                     rd_vld,
  input  logic [$clog2(SLOTS)-1:0] rd_idx,
  input  logic                     rd_valid,
  input  logic [STATE_W-1:0]       rd_state,
  input  logic [CTR_W-1:0]         rd_ctr,
  input  logic [PRIORITY_BITS-1:0] rd_prio,
  input  logic [DEPTH_W-1:0]       rd_depth,
  // compare unit
  output pick_ctl_t                pick_ctl,
  input  logic                     found,
  input  logic [CTR_W-1:0]         best,
  input  logic [$clog2(SLOTS)-1:0] sel,
  input  logic [CTR_W-1:0]         ctr0
);

  localparam int SW = $clog2(SLOTS);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_APPLY  = 8'b0000_0010,
    ST_SCAN   = 8'b0000_0100,
    ST_SDRAIN = 8'b0000_1000,
    ST_DECIDE = 8'b0001_0000,
    ST_RCHG   = 8'b0010_0000,
    ST_RDRAIN = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  // latched command beat
  cmd_t                 cmd_q;
  logic [IDX_IN_W-1:0]  idx_q;
  logic                 sv_q;
  logic [STATE_W-1:0]   ss_q;
  logic [PRIO_IN_W-1:0] sp_q;
  logic [CTR_W-1:0]     sc_q;

  logic [SW-1:0]        running;
  logic [SW-1:0]        prev;
  logic [TICK_W-1:0]    ticks;
  logic [SW-1:0]        scan_idx;
  logic                 second;
  logic                 rech;
  logic [CTR_W-1:0]     res_ctr;

  // command results on the running slot
  logic [CTR_W-1:0]      cur_ctr;
  logic [STATE_W-1:0]    cur_state;
  logic [DEPTH_W-1:0]    cur_depth;
  logic                  cur_wr;
  logic                  sched;
  logic                  tick_inc;
  logic                  in_range;
  logic [SW-1:0]         widx;
  logic [PRIO_MAX_W-1:0] prio_wide;
  logic [CTR_W-1:0]      apply_ctr;
  logic                  load_out;

  assign in_range  = (32'(idx_q) < SLOTS);
  assign widx      = SW'(idx_q);
  assign prio_wide = PRIO_MAX_W'(sp_q);
  assign in_ready  = (state == ST_IDLE);
  assign load_out  = (state == ST_FINISH) && (!out_valid || out_ready);

  // command decode against the running slot's entry
  always_comb begin
    cur_ctr   = rd_ctr;
    cur_state = rd_state;
    cur_depth = rd_depth;
    cur_wr    = 1'b0;
    sched     = 1'b0;
    tick_inc  = 1'b0;
    apply_ctr = rd_ctr;
    unique case (cmd_q)
      CMD_TICK: begin
        cur_ctr   = (rd_ctr == '0) ? '0 : CTR_W'(rd_ctr - 8'd1);
        cur_wr    = 1'b1;
        tick_inc  = 1'b1;
        sched     = (cur_ctr == '0) && (rd_depth == '0);
        apply_ctr = cur_ctr;
      end
      CMD_YIELD: begin
        cur_ctr   = '0;
        cur_wr    = 1'b1;
        sched     = 1'b1;
        apply_ctr = '0;
      end
      CMD_EXIT: begin
        cur_state = rd_valid ? RS_EXIT : rd_state;
        cur_ctr   = '0;
        cur_wr    = 1'b1;
        sched     = 1'b1;
        apply_ctr = '0;
      end
      CMD_PDIS: begin
        cur_depth = (rd_depth == DEPTH_MAX) ? rd_depth : DEPTH_W'(rd_depth + 4'd1);
        cur_wr    = 1'b1;
      end
      CMD_PEN: begin
        cur_depth = (rd_depth == '0) ? rd_depth : DEPTH_W'(rd_depth - 4'd1);
        cur_wr    = 1'b1;
      end
      CMD_WRITE: begin
        apply_ctr = (in_range && (widx == running)) ? sc_q : rd_ctr;
      end
      default: ;
    endcase
  end

  // slot table ports and compare unit steering
  always_comb begin
    wr_en       = 1'b0;
    wr_depth_en = 1'b0;
    wr_addr     = running;
    wr_valid    = rd_valid;
    wr_state    = cur_state;
    wr_ctr      = cur_ctr;
    wr_prio     = rd_prio;
    wr_depth    = cur_depth;
    rd_en       = 1'b0;
    rd_addr     = running;
    pick_ctl    = '0;
    unique case (state)
      ST_IDLE: begin
        rd_en = in_valid;
      end
      ST_APPLY: begin
        if (cmd_q == CMD_WRITE) begin
          // any slot; its depth store is left untouched
          wr_en    = in_range;
          wr_addr  = widx;
          wr_valid = sv_q;
          wr_state = ss_q;
          wr_ctr   = sc_q;
          wr_prio  = prio_wide[PRIORITY_BITS-1:0];
        end else begin
          wr_en       = cur_wr;
          wr_depth_en = cur_wr;
        end
        pick_ctl.clear = sched;
      end
      ST_SCAN: begin
        rd_en         = 1'b1;
        rd_addr       = scan_idx;
        pick_ctl.step = rd_vld;
      end
      ST_SDRAIN: begin
        pick_ctl.step = rd_vld;
      end
      ST_RCHG, ST_RDRAIN: begin
        rd_en    = (state == ST_RCHG);
        rd_addr  = scan_idx;
        wr_en    = rd_vld && rd_valid;
        wr_addr  = rd_idx;
        wr_state = rd_state;
        wr_ctr   = recharge(rd_ctr, PRIO_MAX_W'(rd_prio));
        wr_depth = rd_depth;
        pick_ctl.clear = (state == ST_RDRAIN);
      end
      default: ;
    endcase
  end

  // sequencer and architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      running   <= '0;
      ticks     <= '0;
      second    <= 1'b0;
      rech      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            second <= 1'b0;
            rech   <= 1'b0;
            state  <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (tick_inc) begin
            ticks <= ticks + 32'd1;
          end
          state <= sched ? ST_SCAN : ST_FINISH;
        end
        ST_SCAN: begin
          if (scan_idx == LAST) begin
            state <= ST_SDRAIN;
          end
        end
        ST_SDRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!second && found && (best == '0)) begin
            second <= 1'b1;
            rech   <= 1'b1;
            state  <= ST_RCHG;
          end else begin
            running <= found ? sel : '0;
            state   <= ST_FINISH;
          end
        end
        ST_RCHG: begin
          if (scan_idx == LAST) begin
            state <= ST_RDRAIN;
          end
        end
        ST_RDRAIN: begin
          state <= ST_SCAN;
        end
        ST_FINISH: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cmd_q <= cmd_t'(cmd);
      idx_q <= slot_index;
      sv_q  <= slot_valid;
      ss_q  <= slot_state;
      sp_q  <= slot_priority;
      sc_q  <= slot_counter;
      prev  <= running;
    end
    // scan index: reset at the start of each sweep, else walk forward
    if (state == ST_APPLY || state == ST_DECIDE || state == ST_RDRAIN) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN || state == ST_RCHG) begin
      scan_idx <= SW'(scan_idx + 1'b1);
    end
    if (state == ST_APPLY) begin
      res_ctr <= apply_ctr;
    end else if (state == ST_DECIDE) begin
      res_ctr <= found ? best : ctr0;
    end
    if (load_out) begin
      current_slot    <= SLOT_OUT_W'(running);
      previous_slot   <= SLOT_OUT_W'(prev);
      switched        <= (running != prev);
      recharged       <= rech;
      tick_count      <= ticks;
      current_counter <= res_ctr;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/counter_priority_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// counter_priority_scheduler_core
// Time-slice task scheduler over a table of process slots, stream ports.
// ----------------------------------------------------------------------------
// One command beat in, one result beat out. The block works on one command
// at a time: s_tready is high only while it is idle. Commands that do not
// schedule (preempt disable/enable, slot write, spare codes, a tick that
// leaves the slice running) go from accept through the apply and finish
// states to the result register. A scheduling pass walks the slot table
// through the single read port of the slot memory, one slot per cycle;
// when every runnable counter is zero a recharge sweep and a second walk
// follow. The next command is accepted the cycle after the result is
// registered; the result register lets it wait on m_tready without
// stalling the input. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_priority_scheduler_core
  import csch_pkg::*;
#(
  parameter int SLOTS         = SLOTS_DEF,
  parameter int PRIORITY_BITS = PRIO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot_index[3:0], slot_valid[4], slot_state[6:5], slot_priority[13:7],
  // slot_counter[21:14], zero fill [23:22]
  input  logic [23:0] s_tdata,
  // cmd[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // current_slot[3:0], previous_slot[7:4], switched[8], recharged[9],
  // tick_count[41:10], current_counter[49:42], zero fill [55:50]
  output logic [55:0] m_tdata
);

  localparam int SW = $clog2(SLOTS);

  logic                     wr_en;
  logic                     wr_depth_en;
  logic [SW-1:0]            wr_addr;
  logic                     wr_valid;
  logic [STATE_W-1:0]       wr_state;
  logic [CTR_W-1:0]         wr_ctr;
  logic [PRIORITY_BITS-1:0] wr_prio;
  logic [DEPTH_W-1:0]       wr_depth;
  logic                     rd_en;
  logic [SW-1:0]            rd_addr;
  logic                     rd_vld;
  logic [SW-1:0]            rd_idx;
  logic                     rd_valid;
  logic [STATE_W-1:0]       rd_state;
  logic [CTR_W-1:0]         rd_ctr;
  logic [PRIORITY_BITS-1:0] rd_prio;
  logic [DEPTH_W-1:0]       rd_depth;

  pick_ctl_t                pick_ctl;
  logic                     found;
  logic [CTR_W-1:0]         best;
  logic [SW-1:0]            sel;
  logic [CTR_W-1:0]         ctr0;

  logic [SLOT_OUT_W-1:0]    current_slot;
  logic [SLOT_OUT_W-1:0]    previous_slot;
  logic                     switched;
  logic                     recharged;
  logic [TICK_W-1:0]        tick_count;
  logic [CTR_W-1:0]         current_counter;

  // result beat packing
  assign m_tdata = {6'd0, current_counter, tick_count, recharged, switched,
                    previous_slot, current_slot};

  csch_ctrl #(
    .SLOTS         (SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .cmd             (s_tuser),
    .slot_index      (s_tdata[3:0]),
    .slot_valid      (s_tdata[4]),
    .slot_state      (s_tdata[6:5]),
    .slot_priority   (s_tdata[13:7]),
    .slot_counter    (s_tdata[21:14]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .current_slot    (current_slot),
    .previous_slot   (previous_slot),
    .switched        (switched),
    .recharged       (recharged),
    .tick_count      (tick_count),
    .current_counter (current_counter),
    .wr_en           (wr_en),
    .wr_depth_en     (wr_depth_en),
    .wr_addr         (wr_addr),
    .wr_valid        (wr_valid),
    .wr_state        (wr_state),
    .wr_ctr          (wr_ctr),
    .wr_prio         (wr_prio),
    .wr_depth        (wr_depth),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_vld          (rd_vld),
    .rd_idx          (rd_idx),
    .rd_valid        (rd_valid),
    .rd_state        (rd_state),
    .rd_ctr          (rd_ctr),
    .rd_prio         (rd_prio),
    .rd_depth        (rd_depth),
    .pick_ctl        (pick_ctl),
    .found           (found),
    .best            (best),
    .sel             (sel),
    .ctr0            (ctr0)
  );

  csch_slot_mem #(
    .SLOTS         (SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_mem (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en),
    .wr_depth_en (wr_depth_en),
    .wr_addr     (wr_addr),
    .wr_valid    (wr_valid),
    .wr_state    (wr_state),
    .wr_ctr      (wr_ctr),
    .wr_prio     (wr_prio),
    .wr_depth    (wr_depth),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_vld      (rd_vld),
    .rd_idx      (rd_idx),
    .rd_valid    (rd_valid),
    .rd_state    (rd_state),
    .rd_ctr      (rd_ctr),
    .rd_prio     (rd_prio),
    .rd_depth    (rd_depth)
  );

  csch_pick_unit #(
    .SLOTS (SLOTS)
  ) u_pick (
    .clk   (clk),
    .rst   (rst),
    .ctl   (pick_ctl),
    .idx   (rd_idx),
    .valid (rd_valid),
    .state (rd_state),
    .ctr   (rd_ctr),
    .found (found),
    .best  (best),
    .sel   (sel),
    .ctr0  (ctr0)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/csch_checker.sv =====
// ----------------------------------------------------------------------------
// csch_checker
// Port-level checks for the scheduler core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csch_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [23:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // one command at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a command is in progress");

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // switched flag agrees with the slot fields
  a_switch_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8] == (m_tdata[3:0] != m_tdata[7:4])))
    else $error("switched flag disagrees with slot numbers");

  // no result beat straight out of reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind counter_priority_scheduler_core csch_checker u_csch_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of counter_priority_scheduler_core.
// ----------------------------------------------------------------------------
// Commands go in as beats on the slave side. Each accepted beat is run
// through a local model of the slot table, and the outcome is queued. Every
// result beat on the master side is compared field by field with the oldest
// queued outcome. A few directed sequences come first: reset ticks, the case
// with nothing runnable, zero priorities, field extremes, preemption hold-off
// and the spare command codes. A long random mix with random gaps on both
// sides follows.
// ----------------------------------------------------------------------------

module testbench;
  import csch_pkg::*;

  localparam int NSLOTS        = 16;
  localparam int RANDOM_CMDS   = 600;
  localparam int SETTLE_CYCLES = 80;

  // codes outside the defined command set
  localparam logic [CMD_W-1:0]   CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0]   CMD_SPARE7 = 3'd7;
  // run states beyond the package's two
  localparam logic [STATE_W-1:0] RS_OTHER   = 2'd2;
  localparam logic [STATE_W-1:0] RS_BAD     = 2'd3;

  // one command, tdata fields plus the code carried in tuser
  typedef struct packed {
    logic [CMD_W-1:0]     code;
    logic [CTR_W-1:0]     slice;
    logic [PRIO_IN_W-1:0] prio;
    logic [STATE_W-1:0]   state;
    logic                 valid;
    logic [IDX_IN_W-1:0]  idx;
  } sched_cmd_t;

  // one result beat, lowest field last so it maps onto m_tdata[49:0]
  typedef struct packed {
    logic [CTR_W-1:0]      slice;
    logic [TICK_W-1:0]     ticks;
    logic                  recharged;
    logic                  switched;
    logic [SLOT_OUT_W-1:0] prev_slot;
    logic [SLOT_OUT_W-1:0] cur_slot;
  } sched_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  counter_priority_scheduler_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // slot table as the scheduler should hold it
  logic                 slot_live  [NSLOTS];
  logic [STATE_W-1:0]   slot_mode  [NSLOTS];
  logic [CTR_W-1:0]     slot_slice [NSLOTS];
  logic [PRIO_IN_W-1:0] slot_prio  [NSLOTS];
  logic [DEPTH_W-1:0]   slot_hold  [NSLOTS];
  logic [3:0]           run_slot;
  logic [TICK_W-1:0]    ticks_seen;

  sched_result_t scheduler_outcomes[$];
  int            cmds_accepted = 0;
  int            mismatches    = 0;
  bit            tx_idling     = 1'b1;
  bit            rx_idling     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // largest counter among valid runnable slots, lowest index wins ties
  function automatic logic [3:0] busiest_slot(output int best);
    logic [3:0] sel;
    sel  = '0;
    best = -1;
    for (int i = 0; i < NSLOTS; i++) begin
      if (slot_live[i] && slot_mode[i] == RS_RUN && int'(slot_slice[i]) > best) begin
        best = int'(slot_slice[i]);
        sel  = 4'(i);
      end
    end
    return sel;
  endfunction

  // pick, recharge when all runnable slices are spent, pick once more
  function automatic logic reschedule();
    int         best;
    logic [3:0] sel;
    logic [8:0] sum;
    logic       did;
    did = 1'b0;
    sel = busiest_slot(best);
    if (best == 0) begin
      for (int i = 0; i < NSLOTS; i++) begin
        if (slot_live[i]) begin
          sum = 9'(slot_slice[i] >> 1) + 9'(slot_prio[i]);
          slot_slice[i] = (sum > 9'(CTR_MAX)) ? CTR_MAX : sum[7:0];
        end
      end
      did = 1'b1;
      sel = busiest_slot(best);
    end
    run_slot = sel;
    return did;
  endfunction

  // apply one command to the table and return the result beat it should give
  function automatic sched_result_t schedule_step(input sched_cmd_t c);
    sched_result_t r;
    logic [3:0]    prev;
    logic          did;
    prev = run_slot;
    did  = 1'b0;
    case (c.code)
      CMD_TICK: begin
        if (slot_slice[prev] != '0) slot_slice[prev] = slot_slice[prev] - 8'd1;
        ticks_seen = ticks_seen + 32'd1;
        if (slot_slice[prev] == '0 && slot_hold[prev] == '0) did = reschedule();
      end
      CMD_YIELD: begin
        slot_slice[prev] = '0;
        did = reschedule();
      end
      CMD_EXIT: begin
        if (slot_live[prev]) slot_mode[prev] = RS_EXIT;
        slot_slice[prev] = '0;
        did = reschedule();
      end
      CMD_PDIS: begin
        if (slot_hold[prev] != DEPTH_MAX) slot_hold[prev] = slot_hold[prev] + 4'd1;
      end
      CMD_PEN: begin
        if (slot_hold[prev] != '0) slot_hold[prev] = slot_hold[prev] - 4'd1;
      end
      CMD_WRITE: begin
        slot_live[c.idx]  = c.valid;
        slot_mode[c.idx]  = c.state;
        slot_prio[c.idx]  = c.prio;
        slot_slice[c.idx] = c.slice;
      end
      default: begin
      end
    endcase
    r.cur_slot  = run_slot;
    r.prev_slot = prev;
    r.switched  = (run_slot != prev);
    r.recharged = did;
    r.ticks     = ticks_seen;
    r.slice     = slot_slice[run_slot];
    return r;
  endfunction

  // drive one command beat; valid stays high when the next beat follows at once
  task automatic send_beat(input sched_cmd_t c);
    int gap;
    gap = tx_idling ? int'($urandom_range(0, 6)) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c.code;
    s_tdata  <= {2'b00, c.slice, c.prio, c.state, c.valid, c.idx};
    do @(negedge clk); while (s_tready !== 1'b1);
    @(posedge clk);
    scheduler_outcomes.push_back(schedule_step(c));
    cmds_accepted++;
  endtask

  // non-write command, unused fields random
  task automatic send_op(input logic [CMD_W-1:0] code);
    sched_cmd_t c;
    c      = sched_cmd_t'(25'($urandom));
    c.code = code;
    send_beat(c);
  endtask

  task automatic send_write(input logic [3:0] idx, input logic valid,
                            input logic [1:0] state, input logic [6:0] prio,
                            input logic [7:0] slice);
    sched_cmd_t c;
    c = '{code: CMD_WRITE, slice: slice, prio: prio, state: state, valid: valid, idx: idx};
    send_beat(c);
  endtask

  // hold the input off until every outstanding result is back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (scheduler_outcomes.size() != 0);
  endtask

  // ticks straight out of reset: slot 0 has no slice, so each one recharges
  task automatic test_reset_tick();
    send_op(CMD_TICK);
    send_op(CMD_TICK);
    wait_drained();
  endtask

  // slot 0 exits with nothing else runnable: falls back to slot 0
  task automatic test_no_runnable();
    send_op(CMD_EXIT);
    send_op(CMD_TICK);
    wait_drained();
  endtask

  // zero priorities leave counters at zero after a recharge
  task automatic test_zero_priority();
    send_write(4'd0, 1'b1, RS_RUN, 7'd0, 8'd0);
    send_write(4'd5, 1'b1, RS_RUN, 7'd0, 8'd0);
    send_op(CMD_YIELD);
    send_write(4'd5, 1'b1, RS_RUN, 7'd3, 8'd0);
    send_op(CMD_TICK);
    wait_drained();
  endtask

  // field extremes, odd states, and a running slot made invalid
  task automatic test_slot_extremes();
    send_write(4'd15, 1'b1, RS_RUN, 7'd127, 8'd255);
    send_write(4'd1, 1'b0, RS_OTHER, 7'd0, 8'd0);
    send_write(4'd2, 1'b1, RS_BAD, 7'd85, 8'd170);
    send_op(CMD_YIELD);
    send_write(run_slot, 1'b0, RS_RUN, 7'd42, 8'd200);
    send_op(CMD_TICK);
    send_op(CMD_YIELD);
    wait_drained();
  endtask

  // slice runs out while preemption is held off, then release with saturation
  task automatic test_preempt();
    send_write(run_slot, 1'b1, RS_RUN, 7'd1, 8'd2);
    send_op(CMD_PDIS);
    send_op(CMD_PDIS);
    repeat (3) send_op(CMD_TICK);
    repeat (3) send_op(CMD_PEN);
    send_op(CMD_TICK);
    wait_drained();
  endtask

  task automatic test_spare_codes();
    send_op(CMD_SPARE6);
    send_op(CMD_SPARE7);
    wait_drained();
  endtask

  // random mix, small slices and priorities so picks happen often
  task automatic test_random_mix();
    int start;
    int stretch;
    int pick;
    int n;
    logic [1:0] st;
    logic [6:0] pr;
    logic [7:0] sl;
    start   = cmds_accepted;
    stretch = 0;
    while (cmds_accepted - start < RANDOM_CMDS) begin
      if (stretch == 0) begin
        stretch   = $urandom_range(20, 60);
        tx_idling = ($urandom_range(0, 2) != 0);
        rx_idling = ($urandom_range(0, 2) != 0);
      end
      stretch--;
      pick = $urandom_range(0, 199);
      if (pick < 90) send_op(CMD_TICK);
      else if (pick < 108) send_op(CMD_YIELD);
      else if (pick < 116) send_op(CMD_EXIT);
      else if (pick < 126) send_op(CMD_PDIS);
      else if (pick < 138) send_op(CMD_PEN);
      else if (pick < 188) begin
        st = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : RS_RUN;
        pr = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 6));
        sl = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 8));
        send_write(4'($urandom_range(0, 15)), ($urandom_range(0, 9) != 0), st, pr, sl);
      end
      else if (pick < 194) send_op(pick[0] ? CMD_SPARE6 : CMD_SPARE7);
      else if (pick < 199) wait_drained();
      else begin
        // push the hold depth into saturation and back out
        n = $urandom_range(13, 17);
        repeat (n) send_op(CMD_PDIS);
        repeat ($urandom_range(1, 4)) send_op(CMD_TICK);
        repeat (n + 1) send_op(CMD_PEN);
      end
    end
  endtask

  // result side: random stall before each beat
  initial begin
    int gap;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      gap = rx_idling ? int'($urandom_range(0, 6)) : 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (m_tvalid !== 1'b1);
      @(posedge clk);
    end
  end

  // compare each result beat with the oldest predicted outcome
  always @(negedge clk) begin
    sched_result_t got;
    sched_result_t want;
    if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      got = sched_result_t'(m_tdata[49:0]);
      if (scheduler_outcomes.size() == 0) begin
        if (mismatches < 10)
          $display("[%0t] result beat with none outstanding: cur=%0d prev=%0d", $realtime,
                   got.cur_slot, got.prev_slot);
        mismatches++;
      end else begin
        want = scheduler_outcomes.pop_front();
        if (got.cur_slot != want.cur_slot || got.prev_slot != want.prev_slot ||
            got.switched != want.switched || got.recharged != want.recharged ||
            got.ticks != want.ticks || got.slice != want.slice) begin
          if (mismatches < 10) begin
            $display("[%0t] mismatch exp: cur=%0d prev=%0d sw=%0b rch=%0b ticks=%0d ctr=%0d",
                     $realtime, want.cur_slot, want.prev_slot, want.switched,
                     want.recharged, want.ticks, want.slice);
            $display("[%0t]          got: cur=%0d prev=%0d sw=%0b rch=%0b ticks=%0d ctr=%0d",
                     $realtime, got.cur_slot, got.prev_slot, got.switched,
                     got.recharged, got.ticks, got.slice);
          end
          mismatches++;
        end
      end
    end
  end

  // reset, then the tests in turn
  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    for (int i = 0; i < NSLOTS; i++) begin
      slot_live[i]  = (i == 0);
      slot_mode[i]  = RS_RUN;
      slot_slice[i] = '0;
      slot_prio[i]  = 7'd1;
      slot_hold[i]  = '0;
    end
    run_slot   = '0;
    ticks_seen = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_reset_tick();
    test_no_runnable();
    test_zero_priority();
    test_slot_extremes();
    test_preempt();
    test_spare_codes();
    test_random_mix();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && scheduler_outcomes.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
